// ===== design/cvr_pkg.sv =====
`default_nettype none

package cvr_pkg;

    // Capacity of the datapath
    localparam int MAX_IN_CHANNELS  = 4;
    localparam int MAX_OUT_CHANNELS = 8;
    localparam int MAX_KERNEL       = 5;
    localparam int MAX_WIDTH        = 32;
    localparam int MAX_HEIGHT       = 32;

    // Store depths
    localparam int SAMPLE_DEPTH = 4096;
    localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int BIAS_DEPTH   = MAX_OUT_CHANNELS;

    // Field and register widths
    localparam int FUNC_W     = 2;
    localparam int LOAD_IDX_W = 12;
    localparam int VALUE_W    = 16;
    localparam int OC_W       = 3;
    localparam int POS_W      = 5;
    localparam int IN_CH_W    = 3;
    localparam int OUT_CH_W   = 4;
    localparam int KERNEL_W   = 3;
    localparam int DIM_W      = 6;
    localparam int LEAK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Derived internal widths
    localparam int SA_W   = $clog2(SAMPLE_DEPTH);
    localparam int WA_W   = $clog2(WEIGHT_DEPTH);
    localparam int BA_W   = $clog2(BIAS_DEPTH);
    localparam int IC_W   = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int KC_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CW     = $clog2(MAX_IN_CHANNELS + 1);
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int KK_W   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int CKK_W  = $clog2(MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1);
    localparam int PROD_W = 2 * VALUE_W;
    localparam int ACC_W  = 40;
    localparam int A33_W  = 33;
    localparam int LK_W   = A33_W + LEAK_W + 1;

    // Register reset values
    localparam logic [IN_CH_W-1:0]  RST_IN_CH  = 3'd1;
    localparam logic [OUT_CH_W-1:0] RST_OUT_CH = 4'd1;
    localparam logic [KERNEL_W-1:0] RST_KERNEL = 3'd3;
    localparam logic [DIM_W-1:0]    RST_WIDTH  = 6'd32;
    localparam logic [DIM_W-1:0]    RST_HEIGHT = 6'd32;
    localparam logic                RST_MODE   = 1'b0;
    localparam logic [LEAK_W-1:0]   RST_LEAK   = 8'd3;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WEIGHT  = 2'd0,
        FUNC_BIAS    = 2'd1,
        FUNC_SAMPLE  = 2'd2,
        FUNC_COMPUTE = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_CH  = 3'd0,
        CFG_OUT_CH = 3'd1,
        CFG_KERNEL = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4,
        CFG_MODE   = 3'd5,
        CFG_LEAK   = 3'd6
    } t_cfg_idx;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SETUP1 = 3'd1,
        ST_SETUP2 = 3'd2,
        ST_SETUP3 = 3'd3,
        ST_MAC    = 3'd4,
        ST_DRAIN  = 3'd5,
        ST_ACT    = 3'd6,
        ST_FIN    = 3'd7
    } t_state;

endpackage

`default_nettype wire

// ===== design/conv2d_valid_relu_unit.sv =====
`default_nettype none

// Channel   Handshake                     Payload
// input     i_in_valid / o_in_ready       i_func, i_load_index, i_load_value,
//                                         i_out_channel, i_out_row, i_out_col
// output    o_out_valid / i_out_ready     o_result_value, o_status
// config    i_cfg_we (no handshake)       i_cfg_idx, i_cfg_data
//
// Load items may follow each other back to back.
// A compute item runs the setup states SETUP1 to SETUP3, one shared
// 16x16 multiply-accumulate per tap, the drain state, activation, finish.
// A position outside the output goes from idle straight to the finish step.
// Reset is synchronous and active low; the stores are not cleared.
// The finish step holds while the output register is still full.

module conv2d_valid_relu_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input items
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [cvr_pkg::FUNC_W-1:0]         i_func,
    input  wire logic [cvr_pkg::LOAD_IDX_W-1:0]     i_load_index,
    input  wire logic signed [cvr_pkg::VALUE_W-1:0] i_load_value,
    input  wire logic [cvr_pkg::OC_W-1:0]           i_out_channel,
    input  wire logic [cvr_pkg::POS_W-1:0]          i_out_row,
    input  wire logic [cvr_pkg::POS_W-1:0]          i_out_col,
    // result items
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [cvr_pkg::VALUE_W-1:0]      o_result_value,
    output logic                                    o_status,
    // configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [cvr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [cvr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SA_W   = cvr_pkg::SA_W;
    localparam int WA_W   = cvr_pkg::WA_W;
    localparam int BA_W   = cvr_pkg::BA_W;
    localparam int IC_W   = cvr_pkg::IC_W;
    localparam int KC_W   = cvr_pkg::KC_W;
    localparam int CW     = cvr_pkg::CW;
    localparam int KW     = cvr_pkg::KW;
    localparam int WW     = cvr_pkg::WW;
    localparam int OCT_W  = cvr_pkg::OUT_CH_W;
    localparam int HW_W   = cvr_pkg::HW_W;
    localparam int KK_W   = cvr_pkg::KK_W;
    localparam int CKK_W  = cvr_pkg::CKK_W;
    localparam int VW     = cvr_pkg::VALUE_W;
    localparam int PROD_W = cvr_pkg::PROD_W;
    localparam int ACC_W  = cvr_pkg::ACC_W;
    localparam int A33_W  = cvr_pkg::A33_W;
    localparam int LK_W   = cvr_pkg::LK_W;
    localparam int PR_W   = ACC_W + 1;
    localparam int NR_W   = LK_W + 1;

    // Configuration registers
    logic [cvr_pkg::IN_CH_W-1:0]  r_in_ch;
    logic [cvr_pkg::OUT_CH_W-1:0] r_out_ch;
    logic [cvr_pkg::KERNEL_W-1:0] r_kernel;
    logic [cvr_pkg::DIM_W-1:0]    r_width;
    logic [cvr_pkg::DIM_W-1:0]    r_height;
    logic                         r_mode;
    logic [cvr_pkg::LEAK_W-1:0]   r_leak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= cvr_pkg::RST_IN_CH;
            r_out_ch <= cvr_pkg::RST_OUT_CH;
            r_kernel <= cvr_pkg::RST_KERNEL;
            r_width  <= cvr_pkg::RST_WIDTH;
            r_height <= cvr_pkg::RST_HEIGHT;
            r_mode   <= cvr_pkg::RST_MODE;
            r_leak   <= cvr_pkg::RST_LEAK;
        end else if (i_cfg_we) begin
            unique case (cvr_pkg::t_cfg_idx'(i_cfg_idx))
                cvr_pkg::CFG_IN_CH:  r_in_ch  <= i_cfg_data[cvr_pkg::IN_CH_W-1:0];
                cvr_pkg::CFG_OUT_CH: r_out_ch <= i_cfg_data[cvr_pkg::OUT_CH_W-1:0];
                cvr_pkg::CFG_KERNEL: r_kernel <= i_cfg_data[cvr_pkg::KERNEL_W-1:0];
                cvr_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[cvr_pkg::DIM_W-1:0];
                cvr_pkg::CFG_HEIGHT: r_height <= i_cfg_data[cvr_pkg::DIM_W-1:0];
                cvr_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                cvr_pkg::CFG_LEAK:   r_leak   <= i_cfg_data[cvr_pkg::LEAK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry: zero reads as one, large values clamp to capacity
    logic [CW-1:0]    c_eff;
    logic [OCT_W-1:0] oct_eff;
    logic [KW-1:0]    k_eff;
    logic [WW-1:0]    w_eff;
    logic [WW-1:0]    h_eff;

    always_comb begin
        if (r_in_ch == '0)
            c_eff = CW'(1);
        else if (32'(r_in_ch) > cvr_pkg::MAX_IN_CHANNELS)
            c_eff = CW'(cvr_pkg::MAX_IN_CHANNELS);
        else
            c_eff = CW'(r_in_ch);

        if (r_out_ch == '0)
            oct_eff = OCT_W'(1);
        else if (32'(r_out_ch) > cvr_pkg::MAX_OUT_CHANNELS)
            oct_eff = OCT_W'(cvr_pkg::MAX_OUT_CHANNELS);
        else
            oct_eff = r_out_ch;

        if (r_kernel == '0)
            k_eff = KW'(1);
        else if (32'(r_kernel) > cvr_pkg::MAX_KERNEL)
            k_eff = KW'(cvr_pkg::MAX_KERNEL);
        else
            k_eff = KW'(r_kernel);

        if (r_width == '0)
            w_eff = WW'(1);
        else if (32'(r_width) > cvr_pkg::MAX_WIDTH)
            w_eff = WW'(cvr_pkg::MAX_WIDTH);
        else
            w_eff = WW'(r_width);

        if (r_height == '0)
            h_eff = WW'(1);
        else if (32'(r_height) > cvr_pkg::MAX_HEIGHT)
            h_eff = WW'(cvr_pkg::MAX_HEIGHT);
        else
            h_eff = WW'(r_height);
    end

    // Input handshake and item decode
    cvr_pkg::t_state r_state, n_state;
    logic            in_acc;
    logic            is_compute;
    logic            pos_outside;

    assign o_in_ready = (r_state == cvr_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_compute = (cvr_pkg::t_func'(i_func) == cvr_pkg::FUNC_COMPUTE);

    // Position check: channel in use, kernel fits, row and column inside
    always_comb begin
        pos_outside = ({1'b0, i_out_channel} >= oct_eff)
                   || (WW'(k_eff) > w_eff)
                   || (WW'(k_eff) > h_eff)
                   || ((7'(i_out_row) + 7'(k_eff)) > 7'(h_eff))
                   || ((7'(i_out_col) + 7'(k_eff)) > 7'(w_eff));
    end

    // Captured compute request
    logic [cvr_pkg::OC_W-1:0]  r_oc;
    logic [cvr_pkg::POS_W-1:0] r_row;
    logic [cvr_pkg::POS_W-1:0] r_col;
    logic                      r_outside;

    // Walk state
    logic [KK_W-1:0]  r_kk;
    logic [HW_W-1:0]  r_hw;
    logic [SA_W-1:0]  r_rw;
    logic [CKK_W-1:0] r_ckk;
    logic [SA_W-1:0]  r_sa;
    logic [SA_W-1:0]  r_sa_row;
    logic [SA_W-1:0]  r_sa_plane;
    logic [WA_W-1:0]  r_wa;
    logic [IC_W-1:0]  r_ic;
    logic [KC_W-1:0]  r_ki;
    logic [KC_W-1:0]  r_kj;

    // MAC pipeline
    logic                     r_rd_v;
    logic                     r_p_v;
    logic signed [VW-1:0]     r_s_rd;
    logic signed [VW-1:0]     r_w_rd;
    logic signed [VW-1:0]     r_b_rd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [LK_W-1:0]   r_lk;

    // Output register
    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_value;
    logic                 r_out_status;

    logic kj_last, ki_last, ic_last, mac_last, fin_take;

    assign kj_last  = (KW'(r_kj) == KW'(k_eff - KW'(1)));
    assign ki_last  = (KW'(r_ki) == KW'(k_eff - KW'(1)));
    assign ic_last  = (CW'(r_ic) == CW'(c_eff - CW'(1)));
    assign mac_last = kj_last && ki_last && ic_last;
    assign fin_take = (r_state == cvr_pkg::ST_FIN) && (!r_out_valid || i_out_ready);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= cvr_pkg::ST_IDLE;
        else
            r_state <= n_state;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cvr_pkg::ST_IDLE: begin
                if (in_acc && is_compute)
                    n_state = pos_outside ? cvr_pkg::ST_FIN : cvr_pkg::ST_SETUP1;
            end
            cvr_pkg::ST_SETUP1: n_state = cvr_pkg::ST_SETUP2;
            cvr_pkg::ST_SETUP2: n_state = cvr_pkg::ST_SETUP3;
            cvr_pkg::ST_SETUP3: n_state = cvr_pkg::ST_MAC;
            cvr_pkg::ST_MAC: begin
                if (mac_last)
                    n_state = cvr_pkg::ST_DRAIN;
            end
            cvr_pkg::ST_DRAIN: begin
                // last product lands in the accumulator at this edge
                if (!r_rd_v)
                    n_state = cvr_pkg::ST_ACT;
            end
            cvr_pkg::ST_ACT: n_state = cvr_pkg::ST_FIN;
            cvr_pkg::ST_FIN: begin
                if (fin_take)
                    n_state = cvr_pkg::ST_IDLE;
            end
            default: n_state = cvr_pkg::ST_IDLE;
        endcase
    end

    // Sample store
    logic [VW-1:0] sample_mem [cvr_pkg::SAMPLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (in_acc && cvr_pkg::t_func'(i_func) == cvr_pkg::FUNC_SAMPLE)
            sample_mem[i_load_index[SA_W-1:0]] <= i_load_value;
        if (r_state == cvr_pkg::ST_MAC)
            r_s_rd <= sample_mem[r_sa];
    end

    // Weight store
    logic [VW-1:0] weight_mem [cvr_pkg::WEIGHT_DEPTH];

    always_ff @(posedge i_clk) begin
        if (in_acc && cvr_pkg::t_func'(i_func) == cvr_pkg::FUNC_WEIGHT
            && 32'(i_load_index) < cvr_pkg::WEIGHT_DEPTH)
            weight_mem[i_load_index[WA_W-1:0]] <= i_load_value;
        if (r_state == cvr_pkg::ST_MAC)
            r_w_rd <= weight_mem[r_wa];
    end

    // Bias store
    logic [VW-1:0] bias_mem [cvr_pkg::BIAS_DEPTH];

    always_ff @(posedge i_clk) begin
        if (in_acc && cvr_pkg::t_func'(i_func) == cvr_pkg::FUNC_BIAS
            && 32'(i_load_index) < cvr_pkg::BIAS_DEPTH)
            bias_mem[i_load_index[BA_W-1:0]] <= i_load_value;
        if (r_state == cvr_pkg::ST_SETUP1)
            r_b_rd <= bias_mem[BA_W'(r_oc)];
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_p_v  <= 1'b0;
        end else begin
            r_rd_v <= (r_state == cvr_pkg::ST_MAC);
            r_p_v  <= r_rd_v;
        end
    end

    // Clamp a negative sum to 33 bits; anything lower saturates either way
    logic signed [A33_W-1:0] acc33;

    always_comb begin
        if (&r_acc[ACC_W-1:A33_W-1])
            acc33 = r_acc[A33_W-1:0];
        else
            acc33 = {1'b1, {(A33_W-1){1'b0}}};
    end

    // Address walk, multiply-accumulate and leaky product
    always_ff @(posedge i_clk) begin
        if (in_acc && is_compute) begin
            r_oc      <= i_out_channel;
            r_row     <= i_out_row;
            r_col     <= i_out_col;
            r_outside <= pos_outside;
        end

        if (r_rd_v)
            r_prod <= r_s_rd * r_w_rd;

        unique case (r_state)
            cvr_pkg::ST_SETUP1: begin
                r_kk <= KK_W'(KK_W'(k_eff) * KK_W'(k_eff));
                r_hw <= HW_W'(HW_W'(h_eff) * HW_W'(w_eff));
                r_rw <= SA_W'(SA_W'(r_row) * SA_W'(w_eff));
            end
            cvr_pkg::ST_SETUP2: begin
                r_ckk      <= CKK_W'(CKK_W'(c_eff) * CKK_W'(r_kk));
                r_sa       <= SA_W'(r_rw + SA_W'(r_col));
                r_sa_row   <= SA_W'(r_rw + SA_W'(r_col));
                r_sa_plane <= SA_W'(r_rw + SA_W'(r_col));
                r_acc      <= ACC_W'(r_b_rd) <<< 8;
            end
            cvr_pkg::ST_SETUP3: begin
                r_wa <= WA_W'(WA_W'(r_oc) * WA_W'(r_ckk));
                r_ic <= '0;
                r_ki <= '0;
                r_kj <= '0;
            end
            cvr_pkg::ST_MAC: begin
                r_wa <= WA_W'(r_wa + WA_W'(1));
                if (!kj_last) begin
                    r_kj <= KC_W'(r_kj + KC_W'(1));
                    r_sa <= SA_W'(r_sa + SA_W'(1));
                end else if (!ki_last) begin
                    r_kj     <= '0;
                    r_ki     <= KC_W'(r_ki + KC_W'(1));
                    r_sa_row <= SA_W'(r_sa_row + SA_W'(w_eff));
                    r_sa     <= SA_W'(r_sa_row + SA_W'(w_eff));
                end else if (!ic_last) begin
                    r_kj       <= '0;
                    r_ki       <= '0;
                    r_ic       <= IC_W'(r_ic + IC_W'(1));
                    r_sa_plane <= SA_W'(r_sa_plane + SA_W'(r_hw));
                    r_sa_row   <= SA_W'(r_sa_plane + SA_W'(r_hw));
                    r_sa       <= SA_W'(r_sa_plane + SA_W'(r_hw));
                end
            end
            cvr_pkg::ST_ACT: begin
                r_lk <= acc33 * $signed({1'b0, r_leak});
            end
            default: ;
        endcase

        if (r_p_v)
            r_acc <= r_acc + ACC_W'(r_prod);
    end

    // Rounding and saturation
    logic signed [PR_W-1:0] pos_sum, pos_rnd;
    logic signed [NR_W-1:0] neg_sum, neg_rnd;
    logic signed [VW-1:0]   act_value;

    always_comb begin
        pos_sum = PR_W'(r_acc) + PR_W'(128);
        pos_rnd = pos_sum >>> 8;
        neg_sum = NR_W'(r_lk) + NR_W'(32768);
        neg_rnd = neg_sum >>> 16;
        if (!r_acc[ACC_W-1]) begin
            if (pos_rnd > PR_W'(32767))
                act_value = VW'(32767);
            else
                act_value = VW'(pos_rnd);
        end else if (r_mode) begin
            if (neg_rnd < -NR_W'(32768))
                act_value = {1'b1, {(VW-1){1'b0}}};
            else
                act_value = VW'(neg_rnd);
        end else begin
            act_value = '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (fin_take)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (fin_take) begin
            r_out_value  <= r_outside ? '0 : act_value;
            r_out_status <= r_outside ? cvr_pkg::STATUS_OUTSIDE : cvr_pkg::STATUS_OK;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

`ifndef SYNTHESIS
    // a new result only ever comes from the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == cvr_pkg::ST_FIN))
        else $error("result appeared outside the finish step");

    // tap counters stay inside the configured kernel and channel count
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cvr_pkg::ST_MAC) |->
            (KW'(r_kj) < k_eff && KW'(r_ki) < k_eff && CW'(r_ic) < c_eff))
        else $error("tap counter out of range");

    // the accumulator is complete before activation starts
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cvr_pkg::ST_ACT) |-> (!r_rd_v && !r_p_v))
        else $error("activation started with products in flight");

    // a compute item always leaves idle
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_compute) |=> (r_state != cvr_pkg::ST_IDLE))
        else $error("compute item accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cvr_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_ITEMS  = 750;
    localparam int PHASE_ITEMS   = 60;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic signed [VALUE_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] Q_MIN = 16'sh8000;

    typedef struct {
        t_func                     func;
        logic [LOAD_IDX_W-1:0]     load_index;
        logic signed [VALUE_W-1:0] load_value;
        logic [OC_W-1:0]           out_channel;
        logic [POS_W-1:0]          out_row;
        logic [POS_W-1:0]          out_col;
    } conv_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      status;
    } conv_result_t;

    // DUT ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [FUNC_W-1:0]         i_func = '0;
    logic [LOAD_IDX_W-1:0]     i_load_index = '0;
    logic signed [VALUE_W-1:0] i_load_value = '0;
    logic [OC_W-1:0]           i_out_channel = '0;
    logic [POS_W-1:0]          i_out_row = '0;
    logic [POS_W-1:0]          i_out_col = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [VALUE_W-1:0] o_result_value;
    logic                      o_status;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    // Shadow registers, raw as written
    logic [IN_CH_W-1:0]  reg_in_ch  = RST_IN_CH;
    logic [OUT_CH_W-1:0] reg_out_ch = RST_OUT_CH;
    logic [KERNEL_W-1:0] reg_kernel = RST_KERNEL;
    logic [DIM_W-1:0]    reg_width  = RST_WIDTH;
    logic [DIM_W-1:0]    reg_height = RST_HEIGHT;
    logic                reg_mode   = RST_MODE;
    logic [LEAK_W-1:0]   reg_leak   = RST_LEAK;

    // Shadow stores, updated as items are accepted
    logic signed [VALUE_W-1:0] sample_mem [SAMPLE_DEPTH];
    logic signed [VALUE_W-1:0] weight_mem [WEIGHT_DEPTH];
    logic signed [VALUE_W-1:0] bias_mem   [BIAS_DEPTH];

    // Entries already covered by a queued load
    bit sample_set [SAMPLE_DEPTH];
    bit weight_set [WEIGHT_DEPTH];
    bit bias_set   [BIAS_DEPTH];

    conv_item_t   item_queue[$];
    conv_result_t pending_results[$];
    conv_item_t   cur_item;
    conv_result_t predicted;
    conv_result_t want;

    int items_pushed   = 0;
    int items_accepted = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 28;
    int recv_idle_pct  = 60;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    logic hold_req     = 1'b0;

    conv2d_valid_relu_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_load_index   (i_load_index),
        .i_load_value   (i_load_value),
        .i_out_channel  (i_out_channel),
        .i_out_row      (i_out_row),
        .i_out_col      (i_out_col),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Effective geometry after register saturation
    function automatic void get_geometry(output int c, output int oct, output int k,
                                         output int w, output int h);
        c   = clamp_dim(reg_in_ch, MAX_IN_CHANNELS);
        oct = clamp_dim(reg_out_ch, MAX_OUT_CHANNELS);
        k   = clamp_dim(reg_kernel, MAX_KERNEL);
        w   = clamp_dim(reg_width, MAX_WIDTH);
        h   = clamp_dim(reg_height, MAX_HEIGHT);
    endfunction

    function automatic bit position_valid(int oc, int row, int col);
        int c, oct, k, w, h;
        get_geometry(c, oct, k, w, h);
        if (k > w || k > h || oc >= oct) return 1'b0;
        return row < h - k + 1 && col < w - k + 1;
    endfunction

    // Store update for a load item, or conv + bias + activation for a compute item; returns 1 if a result is due
    function automatic bit predict_item(input conv_item_t it, output conv_result_t res);
        int c, oct, k, w, h, sa, wa;
        longint acc, rounded;
        res.value  = '0;
        res.status = STATUS_OK;
        case (it.func)
            FUNC_WEIGHT: begin
                if (it.load_index < WEIGHT_DEPTH) weight_mem[it.load_index] = it.load_value;
                return 1'b0;
            end
            FUNC_BIAS: begin
                if (it.load_index < BIAS_DEPTH) bias_mem[it.load_index] = it.load_value;
                return 1'b0;
            end
            FUNC_SAMPLE: begin
                sample_mem[it.load_index] = it.load_value;
                return 1'b0;
            end
            default: ;
        endcase
        if (!position_valid(it.out_channel, it.out_row, it.out_col)) begin
            res.status = STATUS_OUTSIDE;
            return 1'b1;
        end
        get_geometry(c, oct, k, w, h);
        acc = 0;
        for (int ic = 0; ic < c; ic++) begin
            for (int ki = 0; ki < k; ki++) begin
                for (int kj = 0; kj < k; kj++) begin
                    sa = ic * h * w + (it.out_row + ki) * w + it.out_col + kj;
                    wa = it.out_channel * c * k * k + ic * k * k + ki * k + kj;
                    acc += longint'(sample_mem[sa]) * longint'(weight_mem[wa]);
                end
            end
        end
        // bias joins as Q16.16
        acc += longint'(bias_mem[it.out_channel]) * 256;
        // round half up to Q8.8; leaky path is Q16.24 before rounding
        if (acc >= 0) begin
            rounded = (acc + 128) >>> 8;
        end else if (reg_mode) begin
            rounded = (acc * longint'(reg_leak) + 32768) >>> 16;
        end else begin
            rounded = 0;
        end
        if (rounded > 32767) rounded = 32767;
        if (rounded < -32768) rounded = -32768;
        res.value = VALUE_W'(rounded);
        return 1'b1;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_q88();
        logic signed [VALUE_W-1:0] v;
        v = VALUE_W'($urandom);
        return v >>> $urandom_range(0, 15);
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IN_CH:  reg_in_ch  = data[IN_CH_W-1:0];
            CFG_OUT_CH: reg_out_ch = data[OUT_CH_W-1:0];
            CFG_KERNEL: reg_kernel = data[KERNEL_W-1:0];
            CFG_WIDTH:  reg_width  = data[DIM_W-1:0];
            CFG_HEIGHT: reg_height = data[DIM_W-1:0];
            CFG_MODE:   reg_mode   = data[0];
            CFG_LEAK:   reg_leak   = data[LEAK_W-1:0];
            default: ;
        endcase
    endfunction

    // One register write; bits above the field width carry junk
    task automatic write_field(logic [CFG_IDX_W-1:0] idx, int val, int width);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] data;
        mask = CFG_DATA_W'((1 << width) - 1);
        data = (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_config(idx, data);
    endtask

    task automatic set_config(int c, int oct, int k, int w, int h, int mode, int leak);
        write_field(CFG_IN_CH, c, IN_CH_W);
        write_field(CFG_OUT_CH, oct, OUT_CH_W);
        write_field(CFG_KERNEL, k, KERNEL_W);
        write_field(CFG_WIDTH, w, DIM_W);
        write_field(CFG_HEIGHT, h, DIM_W);
        write_field(CFG_MODE, mode, 1);
        write_field(CFG_LEAK, leak, LEAK_W);
        write_field(CFG_UNUSED, $urandom, CFG_DATA_W);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block drained: everything sent and answered, then a settle wait
    task automatic wait_idle();
        @(posedge i_clk);
        while (items_accepted != items_pushed || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_item(conv_item_t it);
        case (it.func)
            FUNC_WEIGHT: if (it.load_index < WEIGHT_DEPTH) weight_set[it.load_index] = 1'b1;
            FUNC_BIAS:   if (it.load_index < BIAS_DEPTH) bias_set[it.load_index] = 1'b1;
            FUNC_SAMPLE: sample_set[it.load_index] = 1'b1;
            default: ;
        endcase
        item_queue.push_back(it);
        items_pushed++;
    endfunction

    function automatic void push_load(t_func f, int idx, logic signed [VALUE_W-1:0] v);
        conv_item_t it;
        it.func        = f;
        it.load_index  = LOAD_IDX_W'(idx);
        it.load_value  = v;
        it.out_channel = OC_W'($urandom);
        it.out_row     = POS_W'($urandom);
        it.out_col     = POS_W'($urandom);
        push_item(it);
    endfunction

    // Compute item, preceded by loads for any entry it reads that is not yet written
    function automatic void push_compute(int oc, int row, int col);
        conv_item_t it;
        int c, oct, k, w, h, sa, wa;
        if (position_valid(oc, row, col)) begin
            get_geometry(c, oct, k, w, h);
            for (int ic = 0; ic < c; ic++) begin
                for (int ki = 0; ki < k; ki++) begin
                    for (int kj = 0; kj < k; kj++) begin
                        sa = ic * h * w + (row + ki) * w + col + kj;
                        wa = oc * c * k * k + ic * k * k + ki * k + kj;
                        if (!sample_set[sa]) push_load(FUNC_SAMPLE, sa, rand_q88());
                        if (!weight_set[wa]) push_load(FUNC_WEIGHT, wa, rand_q88());
                    end
                end
            end
            if (!bias_set[oc]) push_load(FUNC_BIAS, oc, rand_q88());
        end
        it.func        = FUNC_COMPUTE;
        it.load_index  = LOAD_IDX_W'($urandom);
        it.load_value  = VALUE_W'($urandom);
        it.out_channel = OC_W'(oc);
        it.out_row     = POS_W'(row);
        it.out_col     = POS_W'(col);
        push_item(it);
    endfunction

    // Input driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (predict_item(cur_item, predicted)) pending_results.push_back(predicted);
                items_accepted <= items_accepted + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (item_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = item_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_func        <= cur_item.func;
                    i_load_index  <= cur_item.load_index;
                    i_load_value  <= cur_item.load_value;
                    i_out_channel <= cur_item.out_channel;
                    i_out_row     <= cur_item.out_row;
                    i_out_col     <= cur_item.out_col;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output backpressure
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("cycle %0d: unexpected result value %0d status %0d",
                                 cycle_count, o_result_value, o_status);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result_value !== want.value || o_status !== want.status) begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("cycle %0d: expected value %0d status %0d, got %0d %0d",
                                     cycle_count, want.value, want.status,
                                     o_result_value, o_status);
                        mismatch_count++;
                    end
                end
            end
            // long hold-off once, to back the block up into its input
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left   <= HOLD_CYCLES;
                hold_done   <= 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int phase, budget, count, start, sel, random_items;
        int c, oct, k, w, h, cr, kr, ke, wr, hr;
        phase = 0;
        random_items = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 1x1 kernel on a 4x4 image, two output channels
        wait_idle();
        set_config(1, 2, 1, 4, 4, 0, 255);
        push_load(FUNC_WEIGHT, 0, Q_MAX);
        push_load(FUNC_WEIGHT, 1, Q_MIN);
        push_load(FUNC_BIAS, 0, Q_MAX);
        push_load(FUNC_BIAS, 1, Q_MIN);
        push_load(FUNC_SAMPLE, 0, Q_MAX);
        push_load(FUNC_SAMPLE, 15, Q_MIN);
        push_compute(0, 0, 0);    // saturates high
        push_compute(1, 0, 0);    // negative, clipped by ReLU
        push_compute(0, 3, 3);    // negative corner
        push_compute(1, 3, 3);    // min times min, saturates high
        push_compute(2, 0, 0);    // channel beyond count
        push_compute(0, 4, 0);    // row beyond output
        push_compute(0, 0, 4);    // column beyond output
        push_compute(7, 31, 31);
        // weight and bias loads past store depth are dropped; sample index 4095 is the last entry
        push_load(FUNC_WEIGHT, 4095, 16'sh0000);
        push_load(FUNC_WEIGHT, WEIGHT_DEPTH, 16'sh0000);
        push_load(FUNC_BIAS, 4095, 16'sh0000);
        push_load(FUNC_BIAS, BIAS_DEPTH, 16'sh0000);
        push_load(FUNC_SAMPLE, 4095, 16'sh1234);
        push_compute(0, 0, 0);
        // leaky with full slope, then zero slope
        wait_idle();
        set_config(1, 2, 1, 4, 4, 1, 255);
        push_compute(1, 0, 0);
        push_compute(0, 3, 3);
        wait_idle();
        set_config(1, 2, 1, 4, 4, 1, 0);
        push_compute(1, 0, 0);
        // kernel wider than image: every position is answered as outside
        wait_idle();
        set_config(1, 2, 5, 4, 4, 0, 3);
        push_compute(0, 0, 0);

        // Random phases
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            if (random_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 28;
                recv_idle_pct = 60;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 60;
                recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            budget = PHASE_ITEMS;
            if (phase == 2) begin
                // every size register above its top, clamps to the largest geometry
                set_config(7, 15, 7, 63, 63, 1, 255);
                budget = 250;
            end else if (phase == 4) begin
                // every size register zero, clamps to one
                set_config(0, 0, 0, 0, 0, 1, 0);
            end else begin
                cr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 2);
                kr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
                ke = clamp_dim(kr, MAX_KERNEL);
                if ($urandom_range(0, 4) == 0) begin
                    wr = $urandom_range(0, 63);
                    hr = $urandom_range(0, 63);
                end else begin
                    wr = ke + $urandom_range(0, 6);
                    hr = ke + $urandom_range(0, 6);
                end
                set_config(cr, $urandom_range(0, 15), kr, wr, hr,
                           $urandom_range(0, 1), $urandom_range(0, 255));
            end
            if (phase == 1) hold_req <= 1'b1;
            get_geometry(c, oct, k, w, h);
            count = 0;
            while (count < budget) begin
                start = items_pushed;
                sel = $urandom_range(0, 99);
                if (sel < 70 && k <= w && k <= h) begin
                    push_compute($urandom_range(0, oct - 1), $urandom_range(0, h - k),
                                 $urandom_range(0, w - k));
                end else if (sel < 85) begin
                    push_compute($urandom_range(0, 7), $urandom_range(0, 31),
                                 $urandom_range(0, 31));
                end else if ($urandom_range(0, 1) == 0) begin
                    push_load(t_func'($urandom_range(0, 2)), $urandom_range(0, 4095),
                              VALUE_W'($urandom));
                end else begin
                    push_load(t_func'($urandom_range(0, 2)), $urandom_range(0, BIAS_DEPTH - 1),
                              rand_q88());
                end
                count += items_pushed - start;
            end
            random_items += count;
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/cvr_pkg.sv
design/conv2d_valid_relu_unit.sv
tb/sv/tb.sv
